### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DNB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dnb assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define DNB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dnb assertion failed");

`endif

### rtl/dnb_pkg.sv
// Package with types and constants of the decimal to negabinary unit.
package dnb_pkg;

  localparam int RESULT_BITS = 128;
  localparam int WORD_BITS   = 32;
  localparam int LIMIT_A     = (RESULT_BITS < 4 * WORD_BITS) ? RESULT_BITS : 4 * WORD_BITS;
  // Largest number of negabinary digits a result may use.
  localparam int LIMIT_BITS  = (LIMIT_A < 128) ? LIMIT_A : 128;
  localparam int ACC_BITS    = 128;
  localparam int CALC_BITS   = ACC_BITS + 32;
  localparam int SLICES      = 4;
  localparam int OUT_W       = 32;
  localparam int MSB_W       = 7;
  localparam int IDX_W       = 2;
  localparam int GRP_BITS    = 8;
  localparam int GROUPS      = LIMIT_BITS / GRP_BITS;

  localparam logic [CALC_BITS-1:0] NEG_MASK = {(CALC_BITS / 2){2'b10}};

  typedef struct packed {
    logic [3:0] digit;
    logic       last_digit;
  } dnb_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] word;
    logic [IDX_W-1:0] word_index;
    logic [MSB_W-1:0] msb_index;
    logic             overflow;
    logic             last_word;
  } dnb_out_t;

  // Finished binary value of one number, handed from the accumulator.
  typedef struct packed {
    logic                valid;
    logic                ovf;
    logic [ACC_BITS-1:0] value;
  } dnb_num_t;

endpackage

### rtl/dnb_accum.sv
// Digit accumulator: folds decimal digits into a binary value and hands off whole numbers.
module dnb_accum import dnb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dnb_in_t  in_data_i,
  output logic     in_stall_o,
  input  logic     take_i,
  output dnb_num_t num_o
);

  logic [ACC_BITS-1:0]  acc_q, acc_d;
  logic                 ovf_q, ovf_d;
  dnb_num_t             num_q, num_d;
  logic [CALC_BITS-1:0] prod;
  logic                 grow_ovf;
  logic                 accept;

  // acc*10 + digit as two shifts and two adds
  assign prod = (CALC_BITS'(acc_q) << 3) + (CALC_BITS'(acc_q) << 1)
              + CALC_BITS'(in_data_i.digit);
  assign grow_ovf   = |prod[CALC_BITS-1:LIMIT_BITS];
  assign in_stall_o = num_q.valid && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    num_d = num_q;
    if (take_i) begin
      num_d.valid = 1'b0;
    end
    if (accept) begin
      if (in_data_i.last_digit) begin
        acc_d       = '0;
        ovf_d       = 1'b0;
        num_d.valid = 1'b1;
        num_d.ovf   = ovf_q | grow_ovf;
        num_d.value = prod[ACC_BITS-1:0];
      end else begin
        acc_d = prod[ACC_BITS-1:0];
        ovf_d = ovf_q | grow_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
      num_q <= '0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
      num_q <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

### rtl/decimal_to_negabinary_unit.sv
// Top level of the decimal to negabinary unit.
//
// Input channel: one decimal digit per beat, most significant first, with
// last_digit set on the final digit of a number. Output channel: the number in
// base -2 as 32-bit slices, slice 0 first, up to the slice holding the top set
// digit; every beat carries msb_index and last_word marks the final slice.
// A number that needs more than LIMIT_BITS digits gives one beat with overflow
// and last_word set and all other fields zero.
// Throughput: one digit per cycle while in_stall_o is low. A number yields
// one to four output beats, one per cycle while out_stall_i is low, drained
// from the result buffer. The finished value registers at the edge that
// accepts the last digit, then the negabinary add registers in stage 2, then
// digit search + buffer load the result buffer, which gives the first beat.
// Reset clears the accumulator, the overflow flag and every stage valid.
// When the receiver stalls, the current beat holds; the add and search stages
// fill up behind it, and only then is in_stall_o raised. Digits of the next
// number keep flowing while earlier results drain.
module decimal_to_negabinary_unit import dnb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dnb_in_t  in_data_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output dnb_out_t out_data_o,
  input  logic     out_stall_i
);

  dnb_num_t num;
  logic     num_take;

  // Stage 2: negabinary form of the finished value
  logic                  s2_v_q;
  logic                  s2_ovf_q;
  logic [LIMIT_BITS-1:0] s2_nb_q;
  logic [CALC_BITS-1:0]  nb_sum;
  logic [CALC_BITS-1:0]  nb_full;
  logic                  nb_ovf;

  // Stage 3: result buffer, drained one slice per beat
  logic                                ob_v_q;
  logic                                ob_ovf_q;
  logic [SLICES-1:0][WORD_BITS-1:0]    ob_nb_q;
  logic [MSB_W-1:0]                    ob_top_q;
  logic [IDX_W-1:0]                    ob_last_q;
  logic [IDX_W-1:0]                    ob_idx_q;

  logic             out_take;
  logic             ob_done;
  logic             ob_free;
  logic             s2_take;
  logic             s2_free;

  logic [GROUPS-1:0] grp_any;
  logic [2:0]        grp_pos [GROUPS];
  logic [MSB_W-1:0]  top_idx;

  dnb_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .take_i     (num_take),
    .num_o      (num)
  );

  // Handoff: each stage advances when the one after it frees up this cycle
  assign out_take = ob_v_q && !out_stall_i;
  assign ob_done  = out_take && (ob_idx_q == ob_last_q);
  assign ob_free  = !ob_v_q || ob_done;
  assign s2_take  = s2_v_q && ob_free;
  assign s2_free  = !s2_v_q || s2_take;
  assign num_take = num.valid && s2_free;

  // (value + ...1010) xor ...1010
  assign nb_sum  = CALC_BITS'(num.value) + NEG_MASK;
  assign nb_full = nb_sum ^ NEG_MASK;
  assign nb_ovf  = |nb_full[CALC_BITS-1:LIMIT_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= num.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (num_take) begin
      s2_ovf_q <= num.ovf | nb_ovf;
      s2_nb_q  <= nb_full[LIMIT_BITS-1:0];
    end
  end

  // Top set digit: find the highest set bit in each byte, then the highest busy byte
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |s2_nb_q[g*GRP_BITS +: GRP_BITS];
      grp_pos[g] = '0;
      for (int b = 0; b < GRP_BITS; b++) begin
        if (s2_nb_q[g*GRP_BITS + b]) begin
          grp_pos[g] = 3'(b);
        end
      end
    end
    top_idx = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (grp_any[g]) begin
        top_idx = MSB_W'(g * GRP_BITS) + MSB_W'(grp_pos[g]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_v_q   <= 1'b0;
      ob_idx_q <= '0;
    end else if (ob_free) begin
      ob_v_q   <= s2_v_q;
      ob_idx_q <= '0;
    end else if (out_take) begin
      ob_idx_q <= ob_idx_q + 1'b1;
    end
  end

  // Overflow loads a zero result with a single slice
  always_ff @(posedge clk_i) begin
    if (s2_take) begin
      ob_ovf_q <= s2_ovf_q;
      if (s2_ovf_q) begin
        ob_nb_q   <= '0;
        ob_top_q  <= '0;
        ob_last_q <= '0;
      end else begin
        ob_nb_q   <= (SLICES * WORD_BITS)'(s2_nb_q);
        ob_top_q  <= top_idx;
        ob_last_q <= IDX_W'(top_idx / WORD_BITS);
      end
    end
  end

  assign out_valid_o           = ob_v_q;
  assign out_data_o.word       = OUT_W'(ob_nb_q[ob_idx_q]);
  assign out_data_o.word_index = ob_idx_q;
  assign out_data_o.msb_index  = ob_top_q;
  assign out_data_o.overflow   = ob_ovf_q;
  assign out_data_o.last_word  = (ob_idx_q == ob_last_q);

endmodule

### rtl/dnb_checker.sv
// Port-level checker for the decimal to negabinary unit and its bind.
`include "assert_macros.svh"

module dnb_checker import dnb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input dnb_in_t  in_data_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input dnb_out_t out_data_o,
  input logic     out_stall_i
);

  logic out_held;
  logic ovf_valid;
  logic ovf_beat_ok;
  logic slice_beat;
  logic last_ok;

  assign out_held    = out_valid_o && out_stall_i;
  assign ovf_valid   = out_valid_o && out_data_o.overflow;
  assign ovf_beat_ok = out_data_o.last_word && (out_data_o.word == '0)
                    && (out_data_o.word_index == '0) && (out_data_o.msb_index == '0);
  assign slice_beat  = out_valid_o && !out_data_o.overflow;
  assign last_ok     = out_data_o.last_word
                    == (32'(out_data_o.word_index) == 32'(out_data_o.msb_index) / WORD_BITS);

  `DNB_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_held, out_valid_o)
  `DNB_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_held, $stable(out_data_o))
  `DNB_ASSERT_IMPL(a_ovf_single, clk_i, rst_ni, ovf_valid, ovf_beat_ok)
  `DNB_ASSERT_IMPL(a_last_slice, clk_i, rst_ni, slice_beat, last_ok)

endmodule

bind decimal_to_negabinary_unit dnb_checker u_dnb_checker (.*);

### sim/dnb_negabinary_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the unit, predicts negabinary result beats and compares them.
module dnb_negabinary_checker import dnb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dnb_in_t  in_data_i,
  input  logic     in_stall_i,
  input  logic     out_valid_i,
  input  dnb_out_t out_data_i,
  input  logic     out_stall_i,
  output int       fail_count_o,
  output int       outstanding_o
);

  localparam int WIDE_BITS   = 160;
  localparam int STORE_BITS  = 128;
  localparam int SHOW_LIMIT  = 10;
  localparam logic [WIDE_BITS-1:0] ALT_MASK = {(WIDE_BITS / 2){2'b10}};

  logic [STORE_BITS-1:0] decimal_acc;
  logic                  acc_overflowed;
  dnb_out_t              expected_slices_q[$];
  int                    mismatches;

  // Fold one digit into the running value; on the last digit queue the result beats.
  function automatic void fold_digit(input logic [3:0] digit, input logic last);
    logic [WIDE_BITS-1:0] scaled;
    logic [WIDE_BITS-1:0] nega;
    dnb_out_t             beat;
    int                   top;
    int                   slices;
    int                   b;
    int                   i;
    scaled = {{(WIDE_BITS - STORE_BITS){1'b0}}, decimal_acc} * WIDE_BITS'(10)
             + WIDE_BITS'(digit);
    if ((scaled >> LIMIT_BITS) != '0)
      acc_overflowed = 1'b1;
    decimal_acc = scaled[STORE_BITS-1:0];
    if (!last)
      return;
    nega = '0;
    if (!acc_overflowed) begin
      // base -2: add the alternating mask, then xor it back out
      nega = ({{(WIDE_BITS - STORE_BITS){1'b0}}, decimal_acc} + ALT_MASK) ^ ALT_MASK;
      if ((nega >> LIMIT_BITS) != '0)
        acc_overflowed = 1'b1;
    end
    if (acc_overflowed) begin
      beat           = '0;
      beat.overflow  = 1'b1;
      beat.last_word = 1'b1;
      expected_slices_q.push_back(beat);
    end else begin
      top = 0;
      for (b = 0; b < WIDE_BITS; b++)
        if (nega[b])
          top = b;
      slices = top / WORD_BITS + 1;
      for (i = 0; i < slices; i++) begin
        beat            = '0;
        beat.word       = OUT_W'(nega >> (i * WORD_BITS));
        beat.word_index = IDX_W'(i);
        beat.msb_index  = MSB_W'(top);
        beat.last_word  = (i == slices - 1);
        expected_slices_q.push_back(beat);
      end
    end
    decimal_acc    = '0;
    acc_overflowed = 1'b0;
  endfunction

  function automatic void check_beat(input dnb_out_t got);
    dnb_out_t want;
    if (expected_slices_q.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t: unexpected result beat word %h idx %0d msb %0d ovf %b last %b",
                 $time, got.word, got.word_index, got.msb_index, got.overflow,
                 got.last_word);
      return;
    end
    want = expected_slices_q.pop_front();
    if (got.word !== want.word || got.word_index !== want.word_index ||
        got.msb_index !== want.msb_index || got.overflow !== want.overflow ||
        got.last_word !== want.last_word) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t: result mismatch, expected word %h idx %0d msb %0d ovf %b last %b",
                 $time, want.word, want.word_index, want.msb_index, want.overflow,
                 want.last_word, "\n    got word %h idx %0d msb %0d ovf %b last %b",
                 got.word, got.word_index, got.msb_index, got.overflow, got.last_word);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decimal_acc    = '0;
      acc_overflowed = 1'b0;
      mismatches     = 0;
      expected_slices_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i)
        check_beat(out_data_i);
      if (in_valid_i && !in_stall_i)
        fold_digit(in_data_i.digit, in_data_i.last_digit);
      fail_count_o  <= mismatches;
      outstanding_o <= expected_slices_q.size();
    end
  end

endmodule

### sim/decimal_to_negabinary_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives digit beats into the unit, stalls its output and gives the verdict.
module decimal_to_negabinary_unit_tb import dnb_pkg::*;;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 12;
  // Long receiver hold-off: far longer than the unit's few internal stages.
  localparam int HOLD_OFF_CYCLES = 300;
  // Quiet time after the last result, well above the unit's latency.
  localparam int SETTLE_CYCLES   = 20;
  // Allow far more than the slowest correct run needs.
  localparam int WATCHDOG_CYCLES = 500000;
  localparam int PHASE_DIGITS    = 80;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  dnb_in_t  in_data_i   = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  dnb_out_t out_data_o;
  logic     out_stall_i = 1'b0;

  int fail_count;
  int outstanding;

  // Sender idle rate is only used by the stimulus process; the receiver's
  // settings are handed over with nonblocking writes so the receiver process
  // sees them at a well-defined edge.
  int send_idle_pct     = 0;
  int recv_stall_pct    = 0;
  int hold_off_tickets  = 0;
  int hold_off_served   = 0;
  int hold_off_left     = 0;
  int digits_sent       = 0;

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  decimal_to_negabinary_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_data_i,
    .in_stall_o,
    .out_valid_o,
    .out_data_o,
    .out_stall_i
  );

  dnb_negabinary_checker negabinary_check (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_data_i,
    .in_stall_i    (in_stall_o),
    .out_valid_i   (out_valid_o),
    .out_data_i    (out_data_o),
    .out_stall_i,
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Receiver: stall at the phase's rate, or hold off for a long stretch when
  // the stimulus asks for one. The stretch is counted here, cycle by cycle.
  always @(posedge clk_i) begin
    if (hold_off_tickets != hold_off_served) begin
      hold_off_served = hold_off_tickets;
      hold_off_left   = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Offer one digit beat, idling first at the sender's rate. Return at the
  // edge that accepts it; in_stall_o read right after the edge still holds
  // the value the unit presented at that edge.
  task automatic send_digit(input logic [3:0] digit, input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {digit, last};
    do @(posedge clk_i); while (in_stall_o);
    digits_sent++;
  endtask

  // Send a number written in decimal, most significant digit first.
  task automatic send_decimal(input string text);
    int i;
    for (i = 0; i < text.len(); i++)
      send_digit(4'(text[i] - 8'h30), i == text.len() - 1);
  endtask

  // Send one well-formed number of random length and content. Most are short;
  // some reach four slices, 39 digits straddle the negabinary limit, and longer
  // ones overflow the accumulator. A few digits above nine go in as well.
  task automatic send_random_number();
    int         len;
    int         pick;
    int         i;
    logic [3:0] digit;
    pick = $urandom_range(99, 0);
    if (pick < 55)
      len = $urandom_range(6, 1);
    else if (pick < 75)
      len = $urandom_range(20, 7);
    else if (pick < 88)
      len = $urandom_range(38, 21);
    else if (pick < 95)
      len = 39;
    else
      len = $urandom_range(50, 40);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99, 0) < 4)
        digit = 4'($urandom_range(15, 10));
      else
        digit = 4'($urandom_range(9, 0));
      send_digit(digit, i == len - 1);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int stop_at;
    send_idle_pct   = idle_pct;
    recv_stall_pct <= stall_pct;
    stop_at         = digits_sent + PHASE_DIGITS;
    while (digits_sent < stop_at)
      send_random_number();
  endtask

  // Pause the sender until every predicted beat has come back. Skip an edge
  // first, since the checker's count is registered after the accepting edge.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int n;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, a lone nine, digits above nine, leading zeros,
    // a two-slice value, a plain two-digit number and a lone three.
    send_decimal("0");
    send_decimal("9");
    send_digit(4'd15, 1'b1);
    send_decimal("007");
    send_digit(4'd1, 1'b0);
    send_digit(4'd12, 1'b1);
    send_decimal("4294967296");
    send_decimal("10");
    send_decimal("3");
    drain_results();

    // Random phases: no idling, sender gaps, receiver stalls, then both light.
    run_phase(0, 0);
    drain_results();
    run_phase(50, 0);
    run_phase(0, 50);

    // Fill the unit: hold the receiver off while single-digit numbers keep
    // coming back to back, so the result buffer and stages back up and the
    // unit stalls its input.
    hold_off_tickets <= hold_off_tickets + 1;
    send_idle_pct = 0;
    for (n = 0; n < 30; n++)
      send_digit(4'($urandom_range(9, 0)), 1'b1);
    drain_results();

    run_phase(7, 7);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

endmodule
